// ===== hdl/srl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the sorted record list.
// No dependencies; imported by srl_ram, srl_ctrl, sorted_record_list and the test files.
package srl_pkg;

	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_DELETE = 2'd1;
	localparam logic [1:0] FN_DUMP   = 2'd2;

	typedef enum logic [2:0] {
		STS_INSERTED  = 3'd0,
		STS_DELETED   = 3'd1,
		STS_NOT_FOUND = 3'd2,
		STS_FULL      = 3'd3,
		STS_RECORD    = 3'd4,
		STS_EMPTY     = 3'd5
	} status_t;

	typedef struct packed {
		logic [31:0]        id;
		logic signed [15:0] math;
		logic signed [15:0] comp;
	} rec_t;

	typedef struct packed {
		status_t status;
		rec_t    rec;
		logic    last;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CHK,
		S_INS_PUT,
		S_DEL_RD,
		S_DEL_CHK,
		S_DMP_RD,
		S_DMP_CHK,
		S_RESP
	} state_t;

endpackage

// ===== hdl/srl_ram.sv =====
`timescale 1ns / 1ps
// Record memory: one write port, one read port, registered read data.
// Depends on srl_pkg for the record type.
module srl_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  srl_pkg::rec_t   wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output srl_pkg::rec_t   rdata
);
	import srl_pkg::*;

	rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/srl_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for insert, delete and dump: walks the record memory one entry
// at a time, shifting entries as it goes. Depends on srl_pkg and drives srl_ram.
module srl_ctrl #(
	parameter int CAPACITY = 32,
	parameter int AW       = 5,
	parameter int CW       = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          func,
	input  logic [31:0]         student_id,
	input  logic signed [15:0]  math_score,
	input  logic signed [15:0]  computer_score,
	output logic                res_valid,
	output srl_pkg::res_t       res,
	input  logic                out_free,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output srl_pkg::rec_t       mem_wdata,
	output logic                mem_re,
	output logic [AW-1:0]       mem_raddr,
	input  srl_pkg::rec_t       mem_rdata
);
	import srl_pkg::*;

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic               found_q;
	status_t            status_q;
	logic [31:0]        id_q;
	logic signed [15:0] math_q;
	logic signed [15:0] comp_q;

	logic          accept;
	logic [AW-1:0] last_idx;
	logic          at_last;
	logic          id_above;
	logic          match;
	logic          found_now;

	assign accept    = req_valid && (state_q == S_IDLE);
	assign last_idx  = AW'(count_q - CW'(1));
	assign at_last   = (idx_q == last_idx);
	assign id_above  = (id_q > mem_rdata.id);
	assign match     = (mem_rdata.id == id_q);
	assign found_now = found_q || match;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (func)
						FN_INSERT: begin
							if (count_q == CAP_C) state_d = S_RESP;
							else if (count_q == '0) state_d = S_INS_PUT;
							else state_d = S_INS_RD;
						end
						FN_DELETE: state_d = (count_q == '0) ? S_RESP : S_DEL_RD;
						FN_DUMP:   state_d = (count_q == '0) ? S_RESP : S_DMP_RD;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_INS_RD:  state_d = S_INS_CHK;
			S_INS_CHK: state_d = (id_above || idx_q == '0) ? S_INS_PUT : S_INS_RD;
			S_INS_PUT: state_d = S_RESP;
			S_DEL_RD:  state_d = S_DEL_CHK;
			S_DEL_CHK: state_d = at_last ? S_RESP : S_DEL_RD;
			S_DMP_RD:  state_d = S_DMP_CHK;
			S_DMP_CHK: begin
				if (out_free) state_d = at_last ? S_IDLE : S_DMP_RD;
			end
			S_RESP: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory and result outputs
	always_comb begin
		req_stall = (state_q != S_IDLE);
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		res_valid = 1'b0;
		res       = '{status: status_q, rec: '{id: id_q, math: '0, comp: '0}, last: 1'b1};
		case (state_q)
			S_INS_RD, S_DEL_RD, S_DMP_RD: mem_re = 1'b1;
			S_INS_CHK: begin
				// move the entry up one slot while the new id still sorts below it
				if (!id_above) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q + AW'(1);
				end
			end
			S_INS_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = '{id: id_q, math: math_q, comp: comp_q};
			end
			S_DEL_CHK: begin
				// past the match, close the gap
				if (found_q) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q - AW'(1);
				end
			end
			S_DMP_CHK: begin
				res_valid = 1'b1;
				res       = '{status: STS_RECORD, rec: mem_rdata, last: at_last};
			end
			S_RESP: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			found_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE:    found_q <= 1'b0;
				S_INS_PUT: count_q <= count_q + CW'(1);
				S_DEL_CHK: begin
					found_q <= found_now;
					if (at_last && found_now) count_q <= count_q - CW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					id_q   <= student_id;
					math_q <= math_score;
					comp_q <= computer_score;
					idx_q  <= (func == FN_INSERT && count_q != '0) ? last_idx : '0;
					case (func)
						FN_INSERT: status_q <= STS_FULL;
						FN_DELETE: status_q <= STS_NOT_FOUND;
						default:   status_q <= STS_EMPTY;
					endcase
				end
			end
			S_INS_CHK: begin
				if (id_above) idx_q <= idx_q + AW'(1);
				else if (idx_q != '0) idx_q <= idx_q - AW'(1);
			end
			S_INS_PUT: status_q <= STS_INSERTED;
			S_DEL_CHK: begin
				if (at_last) status_q <= found_now ? STS_DELETED : STS_NOT_FOUND;
				else idx_q <= idx_q + AW'(1);
			end
			S_DMP_CHK: begin
				if (out_free && !at_last) idx_q <= idx_q + AW'(1);
			end
			default: ;
		endcase
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C) else $error("entry count above capacity");

	a_chk_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_CHK |-> $past(state_q) == S_INS_RD)
		else $error("insert compare without a read issued");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_PUT |-> count_q < CAP_C)
		else $error("insert write into a full list");

	a_del_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q == S_DEL_CHK) |-> idx_q != '0)
		else $error("delete shift below slot zero");

endmodule

// ===== hdl/sorted_record_list.sv =====
`timescale 1ns / 1ps
// sorted_record_list: keeps up to CAPACITY records (id, two signed scores)
// in ascending id order in a single-port-read record memory.
// Request channel (req_valid/req_stall): func selects insert, delete or dump.
// A transaction is taken only while the sequencer is idle; func code 3 is
// dropped with no response. Response channel (rsp_valid/rsp_stall): one
// transaction per insert or delete, one per stored record for a dump (or a
// single empty status), with last set on the final one.
// Each operation walks the memory one entry at a time, reading and then comparing
// each visited entry: insert visits the entries at or above the new id plus the
// one just below it, delete and a dump visit every stored entry, and a full insert,
// an empty dump or a delete on an empty list goes straight to its response.
// The final response goes valid in the same cycle that the sequencer is idle again.
// Responses sit in an output register, so a new request is taken while a
// finished response waits; a stall on rsp holds that register and the sequencer
// on its final status or, during a dump, on the current record.
// Reset clears the entry count and the output valid; memory contents need no
// clearing since only entries below the count are ever read.
module sorted_record_list #(
	parameter int CAPACITY = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          func,
	input  logic [31:0]         student_id,
	input  logic signed [15:0]  math_score,
	input  logic signed [15:0]  computer_score,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [2:0]          status,
	output logic [31:0]         out_id,
	output logic signed [15:0]  out_math,
	output logic signed [15:0]  out_computer,
	output logic                last
);
	import srl_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	rec_t          mem_wdata, mem_rdata;
	logic          res_valid;
	res_t          res;
	logic          out_free;
	logic          rsp_valid_q;
	res_t          rsp_q;

	assign out_free = !rsp_valid_q || !rsp_stall;

	srl_ctrl #(
		.CAPACITY(CAPACITY),
		.AW      (AW),
		.CW      (CW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.func          (func),
		.student_id    (student_id),
		.math_score    (math_score),
		.computer_score(computer_score),
		.res_valid     (res_valid),
		.res           (res),
		.out_free      (out_free),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

	srl_ram #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= res_valid;
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_q.status;
	assign out_id       = rsp_q.rec.id;
	assign out_math     = rsp_q.rec.math;
	assign out_computer = rsp_q.rec.comp;
	assign last         = rsp_q.last;

endmodule

// ===== test/srl_checker.sv =====
`timescale 1ns / 1ps
// Checker for sorted_record_list: models the ordered record store, predicts the
// responses of each accepted request and compares every accepted response.
// Depends on srl_pkg for the function codes, status codes and record types.
module srl_checker #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [1:0]         func,
	input  logic [31:0]        student_id,
	input  logic signed [15:0] math_score,
	input  logic signed [15:0] computer_score,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic [2:0]         status,
	input  logic [31:0]        out_id,
	input  logic signed [15:0] out_math,
	input  logic signed [15:0] out_computer,
	input  logic               last,
	output int                 fail_count,
	output int                 pending,
	output int                 entries,
	output int                 checked
);
	import srl_pkg::*;

	rec_t roster [CAPACITY];
	int   roster_len;
	res_t due_q [$];
	int   mismatches;
	int   n_checked;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t: mismatch on %s: got %08h, expected %08h", $time, what, got, want);
	endtask

	function automatic res_t make_result(input status_t st, input logic [31:0] key,
			input logic signed [15:0] m, input logic signed [15:0] c, input logic fin);
		res_t r;
		r.status = st;
		r.rec.id = key;
		r.rec.math = m;
		r.rec.comp = c;
		r.last = fin;
		return r;
	endfunction

	task automatic predict_request(input logic [1:0] fn, input logic [31:0] key,
			input logic signed [15:0] m, input logic signed [15:0] c);
		int slot;
		int i;
		case (fn)
			FN_INSERT: begin
				if (roster_len >= CAPACITY) begin
					due_q.push_back(make_result(STS_FULL, key, '0, '0, 1'b1));
				end else begin
					// new record goes ahead of any equal keys
					slot = 0;
					while (slot < roster_len && key > roster[slot].id)
						slot++;
					for (i = roster_len; i > slot; i--)
						roster[i] = roster[i - 1];
					roster[slot].id = key;
					roster[slot].math = m;
					roster[slot].comp = c;
					roster_len++;
					due_q.push_back(make_result(STS_INSERTED, key, '0, '0, 1'b1));
				end
			end
			FN_DELETE: begin
				slot = 0;
				while (slot < roster_len && roster[slot].id != key)
					slot++;
				if (slot >= roster_len) begin
					due_q.push_back(make_result(STS_NOT_FOUND, key, '0, '0, 1'b1));
				end else begin
					for (i = slot; i + 1 < roster_len; i++)
						roster[i] = roster[i + 1];
					roster_len--;
					due_q.push_back(make_result(STS_DELETED, key, '0, '0, 1'b1));
				end
			end
			FN_DUMP: begin
				if (roster_len == 0) begin
					due_q.push_back(make_result(STS_EMPTY, key, '0, '0, 1'b1));
				end else begin
					for (i = 0; i < roster_len; i++)
						due_q.push_back(make_result(STS_RECORD, roster[i].id, roster[i].math,
								roster[i].comp, i + 1 == roster_len));
				end
			end
			default: ;	// unused code: dropped by the block
		endcase
	endtask

	task automatic check_response();
		res_t want;
		if (due_q.size() == 0) begin
			report_mismatch("unexpected response id", out_id, '0);
			return;
		end
		want = due_q.pop_front();
		n_checked++;
		if (status !== want.status)
			report_mismatch("status", {29'b0, status}, {29'b0, want.status});
		if (out_id !== want.rec.id)
			report_mismatch("out_id", out_id, want.rec.id);
		if (out_math !== want.rec.math)
			report_mismatch("out_math", 32'(out_math), 32'(want.rec.math));
		if (out_computer !== want.rec.comp)
			report_mismatch("out_computer", 32'(out_computer), 32'(want.rec.comp));
		if (last !== want.last)
			report_mismatch("last", {31'b0, last}, {31'b0, want.last});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roster_len = 0;
			due_q.delete();
			pending <= 0;
			entries <= 0;
		end else begin
			// a response can never belong to a request taken at this same edge
			if (rsp_valid && !rsp_stall)
				check_response();
			if (req_valid && !req_stall)
				predict_request(func, student_id, math_score, computer_score);
			pending <= due_q.size();
			entries <= roster_len;
			fail_count <= mismatches;
			checked <= n_checked;
		end
	end

endmodule

// ===== test/tb_sorted_record_list.sv =====
`timescale 1ns / 1ps
// Testbench top for sorted_record_list: clock, reset, request stimulus and
// response stalls; depends on srl_pkg, the block and srl_checker.
module tb_sorted_record_list;
	import srl_pkg::*;

	localparam int CAPACITY = 32;
	localparam logic [1:0] FN_UNUSED = 2'd3;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         func = FN_INSERT;
	logic [31:0]        student_id = '0;
	logic signed [15:0] math_score = '0;
	logic signed [15:0] computer_score = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [2:0]         status;
	logic [31:0]        out_id;
	logic signed [15:0] out_math;
	logic signed [15:0] out_computer;
	logic               last;

	int fail_count;
	int pending;
	int entries;
	int checked;

	int idle_pct = 0;
	int stall_pct = 0;
	int requests = 0;
	int full_hits = 0;
	logic [31:0] key_log [$];

	sorted_record_list #(.CAPACITY(CAPACITY)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .func(func),
		.student_id(student_id), .math_score(math_score), .computer_score(computer_score),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status), .out_id(out_id),
		.out_math(out_math), .out_computer(out_computer), .last(last)
	);

	srl_checker #(.CAPACITY(CAPACITY)) u_check (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .func(func),
		.student_id(student_id), .math_score(math_score), .computer_score(computer_score),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status), .out_id(out_id),
		.out_math(out_math), .out_computer(out_computer), .last(last),
		.fail_count(fail_count), .pending(pending), .entries(entries), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		#10ms;
		$display("[sorted_record_list] ERROR");
		$finish;
	end

	function automatic logic [31:0] pick_key();
		case ($urandom_range(9))
			0, 1, 2, 3: return 32'($urandom_range(7));
			4: return 32'hFFFF_FFFF - 32'($urandom_range(3));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [15:0] pick_score();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return -16'sd1;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly take back a key that went in, so deletes usually hit
	function automatic logic [31:0] pick_victim();
		int idx;
		logic [31:0] key;
		if (key_log.size() == 0 || $urandom_range(9) < 3)
			return pick_key();
		idx = $urandom_range(key_log.size() - 1);
		key = key_log[idx];
		key_log.delete(idx);
		return key;
	endfunction

	task automatic send_request(input logic [1:0] fn, input logic [31:0] key,
			input logic signed [15:0] m, input logic signed [15:0] c);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			func <= 2'($urandom);
			student_id <= $urandom;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		func <= fn;
		student_id <= key;
		math_score <= m;
		computer_score <= c;
		if (fn != FN_UNUSED)
			requests++;
		// hold the transaction until it is taken
		do @(posedge clk); while (req_stall);
	endtask

	task automatic send_insert(input logic [31:0] key);
		key_log.push_back(key);
		send_request(FN_INSERT, key, pick_score(), pick_score());
	endtask

	task automatic send_simple(input logic [1:0] fn, input logic [31:0] key);
		send_request(fn, key, pick_score(), pick_score());
	endtask

	task automatic drain_responses();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int target;
		int roll;
		int full_run;
		bit growing;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty-store cases, unused code, extremes and duplicate ordering
		send_simple(FN_DUMP, 32'hDEAD_BEEF);
		send_simple(FN_DELETE, 32'h0);
		send_simple(FN_UNUSED, 32'h1234_5678);
		send_request(FN_INSERT, 32'd5, 16'sh7FFF, 16'sh8000);
		send_request(FN_INSERT, 32'd0, 16'sh8000, 16'sh7FFF);
		send_request(FN_INSERT, 32'hFFFF_FFFF, -16'sd1, 16'sd0);
		send_request(FN_INSERT, 32'd5, 16'sd1, 16'sd2);
		send_request(FN_INSERT, 32'd5, 16'sd3, 16'sd4);
		send_simple(FN_DUMP, 32'h0);
		send_simple(FN_DELETE, 32'd5);
		send_simple(FN_DELETE, 32'd7);
		send_simple(FN_DELETE, 32'hFFFF_FFFF);
		send_simple(FN_DUMP, 32'hFFFF_FFFF);
		send_simple(FN_DELETE, 32'd0);
		send_simple(FN_DELETE, 32'd5);
		send_simple(FN_DELETE, 32'd5);
		send_simple(FN_DELETE, 32'd5);
		send_simple(FN_DUMP, 32'h5555_AAAA);
		drain_responses();

		target = requests;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 68; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 68; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			target += 90;
			growing = 1'b1;
			full_run = 0;
			key_log.delete();
			while (requests < target) begin
				roll = $urandom_range(99);
				if (roll < 3) begin
					send_simple(FN_UNUSED, $urandom);
				end else if (growing) begin
					// fill to capacity, knock on the full store, then dump it
					if (entries >= CAPACITY) begin
						send_insert(pick_key());
						full_hits++;
						full_run++;
						if (full_run >= 3) begin
							send_simple(FN_DUMP, pick_key());
							growing = 1'b0;
							full_run = 0;
						end
					end else if (roll < 78) begin
						send_insert(pick_key());
					end else if (roll < 90) begin
						send_simple(FN_DELETE, pick_victim());
					end else begin
						send_simple(FN_DUMP, pick_key());
					end
				end else begin
					if (entries == 0) begin
						send_simple(FN_DUMP, pick_key());
						send_simple(FN_DELETE, pick_key());
						growing = 1'b1;
					end else if (roll < 75) begin
						send_simple(FN_DELETE, pick_victim());
					end else if (roll < 88) begin
						send_insert(pick_key());
					end else begin
						send_simple(FN_DUMP, pick_key());
					end
				end
			end
			drain_responses();
		end

		repeat (100) @(negedge clk);
		$display("Sent %0d requests in four gap/stall phases, %0d of them inserts into a full list.",
				requests, full_hits);
		$display("Checked %0d responses, %0d mismatches.", checked, fail_count);
		if (fail_count == 0)
			$display("[sorted_record_list] OK");
		else
			$display("[sorted_record_list] ERROR");
		$finish;
	end

endmodule
